[rtl/gmdc_pkg.sv]
// Shared constants, register indexes and controller/datapath interface types
// for the grid minimum-distance checker. No dependencies.
`timescale 1ns / 1ps
package gmdc_pkg;

   localparam int GRID_DIM_DEF    = 64;
   localparam int WINDOW_HALF_DEF = 5;

   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int GRID_SIZE_W = 7;
   localparam int INV_CELL_W  = 16;
   localparam int MIN_DIST_W  = 32;
   localparam int POS_W       = 16;
   localparam int PROD_W      = 2 * POS_W;
   localparam int CELL_RAW_W  = PROD_W - 24;
   localparam int GCMP_W      = 9;
   localparam int DIST_W      = PROD_W + 1;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_CELL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DIST  = 2'd2;

   localparam logic [GRID_SIZE_W-1:0] GRID_SIZE_RST = 7'd64;
   localparam logic [INV_CELL_W-1:0]  INV_CELL_RST  = 16'd16384;
   localparam logic [MIN_DIST_W-1:0]  MIN_DIST_RST  = 32'd0;

   // cell entry: {valid, x, y}
   localparam int ENTRY_W   = 1 + 2 * POS_W;
   localparam int VALID_BIT = ENTRY_W - 1;

   localparam logic OP_QUERY  = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   typedef struct packed {
      logic clr_wr;
      logic load;
      logic mul;
      logic map_cell;
      logic ins_wr;
      logic scan_step;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic op_insert;
      logic scan_last;
      logic pipe_busy;
   } dp_status_type;

endpackage

[rtl/gmdc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module gmdc_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/gmdc_ctrl.sv]
// Sequencer for clear pass, insert and window scan.
// Depends on gmdc_pkg.
`timescale 1ns / 1ps
module gmdc_ctrl
   import gmdc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_start,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          busy,
   output logic          rsp_valid
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_CELL  = 3'd3;
   localparam logic [2:0] ST_WRITE = 3'd4;
   localparam logic [2:0] ST_SCAN  = 3'd5;
   localparam logic [2:0] ST_DRAIN = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_start) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_CELL;
         end
         ST_CELL: begin
            cmd.map_cell = 1'b1;
            state_in     = status.op_insert ? ST_WRITE : ST_SCAN;
         end
         ST_WRITE: begin
            cmd.ins_wr = 1'b1;
            state_in   = ST_DONE;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

endmodule

[rtl/gmdc_dp.sv]
// Datapath: config registers, cell mapping, scan counters, distance pipeline
// and the cell store. Depends on gmdc_pkg and gmdc_ram.
`timescale 1ns / 1ps
module gmdc_dp
   import gmdc_pkg::*;
#(
   parameter int GRID_DIM    = GRID_DIM_DEF,
   parameter int WINDOW_HALF = WINDOW_HALF_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_op,
   input  logic [POS_W-1:0]      req_pos_x,
   input  logic [POS_W-1:0]      req_pos_y,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   output logic                  too_close
);

   localparam int CELLS = GRID_DIM * GRID_DIM;
   localparam int AW    = $clog2(CELLS);
   localparam int IW    = $clog2(GRID_DIM);
   localparam int SPAN  = 2 * WINDOW_HALF;
   localparam int OW    = $clog2(SPAN);
   localparam int ZW    = ((IW > OW) ? IW : OW) + 2;

   // configuration
   logic [GRID_SIZE_W-1:0] grid_size_ff, grid_size_in;
   logic [INV_CELL_W-1:0]  inv_cell_ff, inv_cell_in;
   logic [MIN_DIST_W-1:0]  min_dist_ff, min_dist_in;

   always_comb begin
      grid_size_in = grid_size_ff;
      inv_cell_in  = inv_cell_ff;
      min_dist_in  = min_dist_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GRID_SIZE: grid_size_in = csr_wdata[GRID_SIZE_W-1:0];
            CSR_INV_CELL:  inv_cell_in  = csr_wdata[INV_CELL_W-1:0];
            CSR_MIN_DIST:  min_dist_in  = csr_wdata[MIN_DIST_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= GRID_SIZE_RST;
         inv_cell_ff  <= INV_CELL_RST;
         min_dist_ff  <= MIN_DIST_RST;
      end else begin
         grid_size_ff <= grid_size_in;
         inv_cell_ff  <= inv_cell_in;
         min_dist_ff  <= min_dist_in;
      end
   end

   // grid size in use, saturated to 1..GRID_DIM
   logic [GCMP_W-1:0] g_use;
   logic [GCMP_W-1:0] g_m1;

   always_comb begin
      if (grid_size_ff == '0) begin
         g_use = GCMP_W'(1);
      end else if (GCMP_W'(grid_size_ff) > GCMP_W'(GRID_DIM)) begin
         g_use = GCMP_W'(GRID_DIM);
      end else begin
         g_use = GCMP_W'(grid_size_ff);
      end
      g_m1 = g_use - GCMP_W'(1);
   end

   // item capture, cell mapping
   logic             op_ff, op_in;
   logic [POS_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [PROD_W-1:0] prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;
   logic [IW-1:0]    cx_ff, cx_in, cy_ff, cy_in;
   logic [GCMP_W-1:0] raw_x, raw_y;

   assign raw_x = GCMP_W'(prod_x_ff[PROD_W-1 -: CELL_RAW_W]);
   assign raw_y = GCMP_W'(prod_y_ff[PROD_W-1 -: CELL_RAW_W]);

   always_comb begin
      op_in     = cmd.load ? req_op    : op_ff;
      px_in     = cmd.load ? req_pos_x : px_ff;
      py_in     = cmd.load ? req_pos_y : py_ff;
      prod_x_in = cmd.mul ? PROD_W'(px_ff) * PROD_W'(inv_cell_ff) : prod_x_ff;
      prod_y_in = cmd.mul ? PROD_W'(py_ff) * PROD_W'(inv_cell_ff) : prod_y_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      if (cmd.map_cell) begin
         cx_in = (raw_x > g_m1) ? g_m1[IW-1:0] : raw_x[IW-1:0];
         cy_in = (raw_y > g_m1) ? g_m1[IW-1:0] : raw_y[IW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
   end

   // window scan counters
   logic [OW-1:0] oi_ff, oi_in, oj_ff, oj_in;
   logic          oj_wrap;

   assign oj_wrap = (oj_ff == OW'(SPAN - 1));

   always_comb begin
      oi_in = oi_ff;
      oj_in = oj_ff;
      if (cmd.load) begin
         oi_in = '0;
         oj_in = '0;
      end else if (cmd.scan_step) begin
         oj_in = oj_wrap ? '0 : oj_ff + OW'(1);
         oi_in = oj_wrap ? oi_ff + OW'(1) : oi_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oi_ff <= '0;
         oj_ff <= '0;
      end else begin
         oi_ff <= oi_in;
         oj_ff <= oj_in;
      end
   end

   logic [ZW-1:0] i_val, j_val;
   logic          in_grid;

   assign i_val   = ZW'(cx_ff) + ZW'(oi_ff) - ZW'(WINDOW_HALF);
   assign j_val   = ZW'(cy_ff) + ZW'(oj_ff) - ZW'(WINDOW_HALF);
   assign in_grid = !i_val[ZW-1] && (i_val < ZW'(g_use))
                 && !j_val[ZW-1] && (j_val < ZW'(g_use));

   // distance pipeline
   logic              s1_v_ff, s1_v_in, s2_v_ff, s3_v_ff, s3_v_in, s4_v_ff;
   logic [AW-1:0]     s1_addr_ff, s1_addr_in;
   logic [POS_W-1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic [PROD_W-1:0] sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [DIST_W-1:0] dist_sq;
   logic              hit_ff, hit_in;
   logic [ENTRY_W-1:0] rd_data;
   logic [POS_W-1:0]  ex, ey;

   assign ex = rd_data[2*POS_W-1:POS_W];
   assign ey = rd_data[POS_W-1:0];

   always_comb begin
      s1_v_in    = cmd.scan_step && in_grid;
      s1_addr_in = AW'(i_val[IW-1:0]) * AW'(GRID_DIM) + AW'(j_val[IW-1:0]);
      s3_v_in    = s2_v_ff && rd_data[VALID_BIT];
      dx_in      = (ex >= px_ff) ? ex - px_ff : px_ff - ex;
      dy_in      = (ey >= py_ff) ? ey - py_ff : py_ff - ey;
      sqx_in     = PROD_W'(dx_ff) * PROD_W'(dx_ff);
      sqy_in     = PROD_W'(dy_ff) * PROD_W'(dy_ff);
      dist_sq    = DIST_W'(sqx_ff) + DIST_W'(sqy_ff);
      if (cmd.load) begin
         hit_in = 1'b0;
      end else begin
         hit_in = hit_ff || (s4_v_ff && (dist_sq < DIST_W'(min_dist_ff)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         hit_ff  <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s3_v_in;
         s4_v_ff <= s3_v_ff;
         hit_ff  <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff <= s1_addr_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      sqx_ff     <= sqx_in;
      sqy_ff     <= sqy_in;
   end

   // clear pass counter
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;

   assign clr_cnt_in = cmd.clr_wr ? clr_cnt_ff + AW'(1) : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // cell store
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [ENTRY_W-1:0] wr_data;

   assign wr_en   = cmd.clr_wr || cmd.ins_wr;
   assign wr_addr = cmd.clr_wr ? clr_cnt_ff
                               : AW'(cx_ff) * AW'(GRID_DIM) + AW'(cy_ff);
   assign wr_data = cmd.clr_wr ? '0 : {1'b1, px_ff, py_ff};

   gmdc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CELLS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (s1_v_ff),
      .rd_addr (s1_addr_ff),
      .rd_data (rd_data)
   );

   assign status.clr_last  = (clr_cnt_ff == AW'(CELLS - 1));
   assign status.op_insert = (op_ff == OP_INSERT);
   assign status.scan_last = oj_wrap && (oi_ff == OW'(SPAN - 1));
   assign status.pipe_busy = s1_v_ff || s2_v_ff || s3_v_ff || s4_v_ff;
   assign too_close        = hit_ff;

endmodule

[rtl/grid_min_distance_checker_unit.sv]
// Top level of the grid minimum-distance checker: controller plus datapath.
// Depends on gmdc_pkg, gmdc_ctrl, gmdc_dp, gmdc_ram.
//
//   channel   ports                                   transfer when
//   request   req_start, req_op, req_pos_x, req_pos_y  req_start && !busy
//   response  rsp_valid, rsp_too_close                 rsp_valid (one cycle)
//   csr       csr_we, csr_index, csr_wdata             csr_we
//
// Insert: the request passes through the multiply, cell-mapping and write
// states before the response. Query: the (2*WINDOW_HALF)^2 window cells are
// stepped through at one per cycle; in-grid cells are read from the
// single-read-port cell store, then pass a 4-stage distance pipe.
// After reset a clearing pass over all GRID_DIM*GRID_DIM cells (4096 at
// default) holds busy high; csr writes are taken during it.
// One item at a time; the response cannot be stalled.
`timescale 1ns / 1ps
module grid_min_distance_checker_unit
   import gmdc_pkg::*;
#(
   parameter int GRID_DIM    = GRID_DIM_DEF,
   parameter int WINDOW_HALF = WINDOW_HALF_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_start,
   input  logic                  req_op,
   input  logic [POS_W-1:0]      req_pos_x,
   input  logic [POS_W-1:0]      req_pos_y,
   output logic                  busy,
   output logic                  rsp_valid,
   output logic                  rsp_too_close,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   gmdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_start (req_start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   gmdc_dp #(
      .GRID_DIM    (GRID_DIM),
      .WINDOW_HALF (WINDOW_HALF)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_op    (req_op),
      .req_pos_x (req_pos_x),
      .req_pos_y (req_pos_y),
      .cmd       (cmd),
      .status    (status),
      .too_close (rsp_too_close)
   );

endmodule

[rtl/gmdc_checker.sv]
// Port-level assertions for the grid minimum-distance checker, bound to the top.
// Depends on gmdc_pkg and grid_min_distance_checker_unit.
`timescale 1ns / 1ps
module gmdc_checker
   import gmdc_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_start,
   input logic             req_op,
   input logic             busy,
   input logic             rsp_valid,
   input logic             rsp_too_close
);

   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response strobe while idle");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("response not followed by idle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_start && !busy) |=> busy)
      else $error("accepted transfer did not raise busy");

   a_insert_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_start && !busy && (req_op == OP_INSERT)) |-> ##4 (rsp_valid && !rsp_too_close))
      else $error("insert response missing or flagged");

endmodule

bind grid_min_distance_checker_unit gmdc_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_start     (req_start),
   .req_op        (req_op),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_too_close (rsp_too_close)
);
